/* sv/kdhr_pkg.sv */
// Shared types and constants for the key debounce and hold-repeat block.
// No dependencies; every other file of the block imports this package.
package kdhr_pkg;

  localparam int CH_W   = 6;
  localparam int TIME_W = 32;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Event kinds as they appear on the result channel.
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_HELD    = 2'd2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_REPEAT   = 2'd1;
  localparam logic [1:0] REG_ENABLE   = 2'd2;
  localparam logic [1:0] REG_GROUP    = 2'd3;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [15:0] REPEAT_RESET   = 16'd0;
  localparam logic [2:0]  ENABLE_RESET   = 3'd7;
  localparam logic [2:0]  GROUP_RESET    = 3'd0;

  typedef struct packed {
    logic [15:0] settle_ms;
    logic [15:0] repeat_interval_ms;
    logic [2:0]  event_enable;
    logic [2:0]  group_id;
  } cfg_t;

  // One sample as it travels down the pipeline.
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              is_down;
    logic [TIME_W-1:0] now;
  } sample_t;

  // Per-channel record held in the state memory.
  typedef struct packed {
    logic              stable_level;
    logic              last_raw_level;
    logic [TIME_W-1:0] raw_change_time;
    logic [TIME_W-1:0] press_start_time;
    logic [TIME_W-1:0] next_repeat_time;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [TIME_W-1:0] held_for_ms;
  } result_t;

endpackage

/* sv/kdhr_cfg_regs.sv */
// Configuration register file with an APB-style access port.
// Depends on kdhr_pkg for the register indexes and the cfg_t bundle.
module kdhr_cfg_regs import kdhr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ms          <= DEBOUNCE_RESET;
      cfg.repeat_interval_ms <= REPEAT_RESET;
      cfg.event_enable       <= ENABLE_RESET;
      cfg.group_id           <= GROUP_RESET;
    end else if (wr) begin
      case (idx)
        REG_DEBOUNCE: cfg.settle_ms          <= pwdata[15:0];
        REG_REPEAT:   cfg.repeat_interval_ms <= pwdata[15:0];
        REG_ENABLE:   cfg.event_enable       <= pwdata[2:0];
        REG_GROUP:    cfg.group_id           <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg.settle_ms};
      REG_REPEAT:   prdata = {16'd0, cfg.repeat_interval_ms};
      REG_ENABLE:   prdata = {29'd0, cfg.event_enable};
      REG_GROUP:    prdata = {29'd0, cfg.group_id};
      default:      prdata = '0;
    endcase
  end

endmodule

/* sv/kdhr_state_ram.sv */
// Per-channel state: a synchronous memory of entry_t records with
// write-to-read forwarding, plus a row of seen flags cleared by reset.
// Depends on kdhr_pkg for entry_t.
module kdhr_state_ram import kdhr_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic [AW-1:0] seen_addr,
  output logic          seen,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t           mem [DEPTH];
  entry_t           rd_q;
  entry_t           fwd_data;
  logic             fwd;
  logic [DEPTH-1:0] seen_flag;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // A read that lands on the edge where the same entry is written would see
  // the old record, so the written record is kept and used instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flag <= '0;
    end else if (wr_en) begin
      seen_flag[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;
  assign seen    = seen_flag[seen_addr];

endmodule

/* sv/kdhr_update.sv */
// Debounce and repeat decision for one sample against its channel record.
// Pure combinational; depends on kdhr_pkg for cfg_t, sample_t, entry_t.
module kdhr_update import kdhr_pkg::*; (
  input  cfg_t    cfg,
  input  sample_t smp,
  input  logic    seen,
  input  entry_t  rec,
  output logic    wr_en,
  output entry_t  wr_data,
  output result_t res
);

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_target;
  logic [TIME_W-1:0] next_time;
  logic              settled;
  logic              repeat_due;
  logic              fire;
  logic [1:0]        kind;

  assign since_change = smp.now - rec.raw_change_time;
  assign since_press  = smp.now - rec.press_start_time;
  assign since_target = smp.now - rec.next_repeat_time;
  assign next_time    = smp.now + {16'd0, cfg.repeat_interval_ms};
  assign settled      = since_change >= {16'd0, cfg.settle_ms};
  assign repeat_due   = rec.stable_level && rec.last_raw_level &&
                        (cfg.repeat_interval_ms != 16'd0) && !since_target[TIME_W-1];

  always_comb begin
    wr_en           = 1'b0;
    wr_data         = rec;
    fire            = 1'b0;
    kind            = KIND_PRESS;
    res.held_for_ms = '0;
    if (!seen) begin
      // First sample of a channel sets up the record and reports nothing.
      wr_en                   = 1'b1;
      wr_data.stable_level    = smp.is_down;
      wr_data.last_raw_level  = smp.is_down;
      wr_data.raw_change_time = smp.now;
      if (smp.is_down) begin
        wr_data.press_start_time = smp.now;
        wr_data.next_repeat_time = next_time;
      end
    end else if (rec.last_raw_level != smp.is_down) begin
      wr_en                   = 1'b1;
      wr_data.last_raw_level  = smp.is_down;
      wr_data.raw_change_time = smp.now;
    end else if (rec.stable_level != smp.is_down) begin
      if (settled) begin
        wr_en                = 1'b1;
        fire                 = 1'b1;
        wr_data.stable_level = smp.is_down;
        if (smp.is_down) begin
          wr_data.press_start_time = smp.now;
          wr_data.next_repeat_time = next_time;
          kind                     = KIND_PRESS;
        end else begin
          kind            = KIND_RELEASE;
          res.held_for_ms = since_press;
        end
      end
    end else if (repeat_due) begin
      wr_en                    = 1'b1;
      fire                     = 1'b1;
      wr_data.next_repeat_time = next_time;
      kind                     = KIND_HELD;
      res.held_for_ms          = since_press;
    end
    res.kind  = kind;
    res.valid = fire && cfg.event_enable[kind];
  end

endmodule

/* sv/key_debounce_hold_repeat.sv */
// Top level of the key debounce and hold-repeat block.
// Uses kdhr_pkg, kdhr_cfg_regs, kdhr_state_ram and kdhr_update.
//
//   channel   direction  handshake               payload
//   sample    in         sample_valid/stall      channel_index, is_down, sample_time_ms
//   event     out        event_valid/stall       source_group .. held_for_ms
//   config    in/out     APB psel/penable/pready paddr, pwdata, prdata
//
// A sample transfer reads its channel record and registers the sample into the
// decision stage, which decides, writes the record back and loads the event
// register as soon as the event register is free; one sample enters per cycle
// unless the event side stalls. A sample right behind one of the same channel
// takes the written record through a forwarding path.
// Reset is synchronous and clears the seen flags at once; no sweep is needed.
// A stalled event register holds the decision stage, which stalls samples.
module key_debounce_hold_repeat import kdhr_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [CH_W-1:0]   channel_index,
  input  logic              is_down,
  input  logic [TIME_W-1:0] sample_time_ms,
  output logic              event_valid,
  input  logic              event_stall,
  output logic [2:0]        source_group,
  output logic [CH_W-1:0]   event_key,
  output logic [1:0]        event_kind,
  output logic [TIME_W-1:0] event_time_ms,
  output logic [TIME_W-1:0] held_for_ms
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t    cfg;
  sample_t s1;
  logic    s1_valid;
  logic    accept;
  logic    event_free;
  logic    in_range;
  logic [8:0] ch_ext;
  logic [8:0] s1_ch_ext;
  entry_t  rec;
  entry_t  wr_data;
  logic    wr_en;
  logic    seen;
  result_t res;

  kdhr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign event_free   = !event_valid || !event_stall;
  assign sample_stall = s1_valid && !event_free;
  assign accept       = sample_valid && !sample_stall;
  assign ch_ext       = {3'd0, channel_index};
  assign s1_ch_ext    = {3'd0, s1.channel};
  assign in_range     = ch_ext < 9'(CHANNELS);

  // Samples for channels beyond the memory are taken and dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= in_range;
    end else if (event_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.channel <= channel_index;
      s1.is_down <= is_down;
      s1.now     <= sample_time_ms;
    end
  end

  kdhr_state_ram #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (ch_ext[AW-1:0]),
    .rd_data   (rec),
    .seen_addr (s1_ch_ext[AW-1:0]),
    .seen      (seen),
    .wr_en     (s1_valid && event_free && wr_en),
    .wr_addr   (s1_ch_ext[AW-1:0]),
    .wr_data   (wr_data)
  );

  kdhr_update u_upd (
    .cfg     (cfg),
    .smp     (s1),
    .seen    (seen),
    .rec     (rec),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (event_free) begin
      event_valid <= s1_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_free && s1_valid && res.valid) begin
      source_group  <= cfg.group_id;
      event_key     <= s1.channel;
      event_kind    <= res.kind;
      event_time_ms <= s1.now;
      held_for_ms   <= res.held_for_ms;
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for key_debounce_hold_repeat: directed and random key samples
// run through the sample channel, with a scoreboard class that predicts every event.
// Depends on kdhr_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import kdhr_pkg::*;

  localparam int NUM_CHANNELS    = 64;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_ITEMS     = 210;
  localparam int RANDOM_PHASES   = 8;
  localparam int MAX_REPORTS     = 20;

  typedef struct {
    logic [2:0]  grp;
    logic [5:0]  channel;
    logic [1:0]  kind;
    logic [31:0] at_ms;
    logic [31:0] held_ms;
  } key_event_t;

  // Tracks the debounce state of every channel and the events still owed by the block.
  class key_event_scoreboard;
    logic [15:0] settle_ms;
    logic [15:0] repeat_ms;
    logic [2:0]  enable_mask;
    logic [2:0]  group_id;
    bit          seen [NUM_CHANNELS];
    bit          stable [NUM_CHANNELS];
    bit          raw [NUM_CHANNELS];
    logic [31:0] change_ms [NUM_CHANNELS];
    logic [31:0] press_ms [NUM_CHANNELS];
    logic [31:0] next_repeat_ms [NUM_CHANNELS];
    key_event_t  awaited_events [$];
    int          mismatches;
    int          samples_taken;
    int          events_checked;
    int          kind_count [3];

    function new();
      settle_ms   = DEBOUNCE_RESET;
      repeat_ms   = REPEAT_RESET;
      enable_mask = ENABLE_RESET;
      group_id    = GROUP_RESET;
      foreach (seen[i]) begin
        seen[i]   = 1'b0;
        stable[i] = 1'b0;
        raw[i]    = 1'b0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_DEBOUNCE: settle_ms = value[15:0];
        REG_REPEAT:   repeat_ms = value[15:0];
        REG_ENABLE:   enable_mask = value[2:0];
        REG_GROUP:    group_id = value[2:0];
        default: ;
      endcase
    endfunction

    function void owe_event(logic [5:0] ch, logic [1:0] kind, logic [31:0] now,
                            logic [31:0] held);
      key_event_t ev;
      if (!enable_mask[kind]) return;
      ev.grp     = group_id;
      ev.channel = ch;
      ev.kind    = kind;
      ev.at_ms   = now;
      ev.held_ms = held;
      awaited_events.push_back(ev);
    endfunction

    // Applies one accepted sample to the channel state and queues any event it causes.
    function void note_sample(logic [5:0] ch, logic down, logic [31:0] now);
      logic [31:0] since;
      samples_taken++;
      if (!seen[ch]) begin
        seen[ch]      = 1'b1;
        stable[ch]    = down;
        raw[ch]       = down;
        change_ms[ch] = now;
        if (down) begin
          press_ms[ch]       = now;
          next_repeat_ms[ch] = now + repeat_ms;
        end
        return;
      end
      if (raw[ch] != down) begin
        raw[ch]       = down;
        change_ms[ch] = now;
        return;
      end
      if (stable[ch] != down) begin
        since = now - change_ms[ch];
        if (since < {16'd0, settle_ms}) return;
        stable[ch] = down;
        if (down) begin
          press_ms[ch]       = now;
          next_repeat_ms[ch] = now + repeat_ms;
          owe_event(ch, KIND_PRESS, now, 32'd0);
        end else begin
          owe_event(ch, KIND_RELEASE, now, now - press_ms[ch]);
        end
        return;
      end
      if (stable[ch] && raw[ch] && repeat_ms != 16'd0) begin
        // The repeat time counts as reached while now is not behind it by half the range.
        since = now - next_repeat_ms[ch];
        if (!since[31]) begin
          next_repeat_ms[ch] = now + repeat_ms;
          owe_event(ch, KIND_HELD, now, now - press_ms[ch]);
        end
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_event(logic [2:0] grp, logic [5:0] ch, logic [1:0] kind, logic [31:0] at_ms,
                     logic [31:0] held);
      key_event_t ev;
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event ch %0d kind %0d at %0d", ch, kind, at_ms));
        return;
      end
      ev = awaited_events.pop_front();
      events_checked++;
      if (ev.kind < 3) kind_count[ev.kind]++;
      if (grp !== ev.grp)
        report_mismatch($sformatf("source_group %0d, want %0d", grp, ev.grp));
      if (ch !== ev.channel)
        report_mismatch($sformatf("event_key %0d, want %0d", ch, ev.channel));
      if (kind !== ev.kind)
        report_mismatch($sformatf("event_kind %0d, want %0d (ch %0d)", kind, ev.kind, ev.channel));
      if (at_ms !== ev.at_ms)
        report_mismatch($sformatf("event_time_ms %0h, want %0h", at_ms, ev.at_ms));
      if (held !== ev.held_ms)
        report_mismatch($sformatf("held_for_ms %0h, want %0h (ch %0d)", held, ev.held_ms,
                                  ev.channel));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  logic [CH_W-1:0]   channel_index = '0;
  logic              is_down = 1'b0;
  logic [TIME_W-1:0] sample_time_ms = '0;
  logic              event_valid;
  logic              event_stall = 1'b0;
  logic [2:0]        source_group;
  logic [CH_W-1:0]   event_key;
  logic [1:0]        event_kind;
  logic [TIME_W-1:0] event_time_ms;
  logic [TIME_W-1:0] held_for_ms;

  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;
  int settings_used = 0;
  key_event_scoreboard board = new();

  key_debounce_hold_repeat DUT (.*);

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [15:0] rep,
                            input logic [2:0] en, input logic [2:0] grp);
    write_reg(REG_DEBOUNCE, {16'd0, deb});
    write_reg(REG_REPEAT, {16'd0, rep});
    write_reg(REG_ENABLE, {29'd0, en});
    write_reg(REG_GROUP, {29'd0, grp});
    settings_used++;
  endtask

  // Offers one sample and returns once the block has taken the transfer.
  task automatic send_sample(input logic [5:0] ch, input logic down, input logic [31:0] t);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid   <= 1'b1;
    channel_index  <= ch;
    is_down        <= down;
    sample_time_ms <= t;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    board.note_sample(ch, down, t);
  endtask

  // Waits until every owed event has arrived, then lets the pipeline empty out, since
  // the last samples may have caused no event at all.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // Reset settings: settle time 20, no repeats, everything enabled.
    send_sample(6'd0, 1'b0, 32'd0);
    send_sample(6'd0, 1'b1, 32'd5);
    send_sample(6'd0, 1'b1, 32'd24);
    send_sample(6'd0, 1'b1, 32'd25);
    send_sample(6'd0, 1'b1, 32'd1000);
    send_sample(6'd0, 1'b0, 32'd1010);
    send_sample(6'd0, 1'b0, 32'd1030);
    // First sample already pressed, then release and press across the time wrap.
    send_sample(6'd63, 1'b1, 32'hFFFF_FFF0);
    send_sample(6'd63, 1'b0, 32'hFFFF_FFF8);
    send_sample(6'd63, 1'b0, 32'h0000_000C);
    send_sample(6'd63, 1'b1, 32'hFFFF_FFFF);
    send_sample(6'd63, 1'b1, 32'h0000_0013);
    drain();
    // The repeat time was set while the interval was zero; it now comes due.
    set_config(16'd0, 16'd1, 3'd7, 3'd7);
    send_sample(6'd63, 1'b1, 32'h0000_0014);
    send_sample(6'd63, 1'b1, 32'h0000_0014);
    send_sample(6'd63, 1'b1, 32'h0000_0015);
    send_sample(6'd5, 1'b0, 32'd100);
    send_sample(6'd5, 1'b1, 32'd100);
    send_sample(6'd5, 1'b1, 32'd100);
    drain();
    // All event kinds masked: state moves on, nothing comes out.
    set_config(16'hFFFF, 16'hFFFF, 3'd0, 3'd5);
    send_sample(6'd5, 1'b1, 32'd65635);
    send_sample(6'd5, 1'b0, 32'd200000);
    send_sample(6'd5, 1'b0, 32'd265535);
    send_sample(6'd5, 1'b1, 32'd265535);
    drain();
  endtask

  task automatic random_config();
    int r;
    logic [15:0] deb;
    logic [15:0] rep;
    logic [2:0]  en;
    r = $urandom_range(0, 99);
    if (r < 25) deb = 16'($urandom_range(0, 3));
    else if (r < 85) deb = 16'($urandom_range(4, 60));
    else if (r < 95) deb = 16'($urandom_range(200, 2000));
    else deb = 16'hFFFF;
    r = $urandom_range(0, 99);
    if (r < 25) rep = 16'd0;
    else if (r < 85) rep = 16'($urandom_range(1, 50));
    else if (r < 95) rep = 16'($urandom_range(100, 500));
    else rep = 16'hFFFF;
    en = ($urandom_range(0, 99) < 70) ? 3'd7 : 3'($urandom_range(0, 7));
    set_config(deb, rep, en, 3'($urandom_range(0, 7)));
  endtask

  // Mostly press/hold/release activity with bounce on a few channels, plus some noise.
  task automatic run_random_phase(input int count, input logic [31:0] start_ms,
                                  input bit with_hold_off);
    logic [5:0]  active [6];
    bit          intent [NUM_CHANNELS];
    logic [31:0] now_ms;
    logic [31:0] t;
    logic [5:0]  ch;
    logic        down;
    int          step_max;
    int          pick;
    now_ms = start_ms;
    foreach (active[i]) active[i] = 6'($urandom_range(0, NUM_CHANNELS - 1));
    foreach (intent[i]) intent[i] = 1'($urandom_range(0, 1));
    step_max = (board.settle_ms > board.repeat_ms) ? int'(board.settle_ms) :
                                                     int'(board.repeat_ms);
    if (with_hold_off) begin
      no_gaps      = 1'b1;
      hold_off_req = 1'b1;
    end
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0 && !(with_hold_off && n == 0))
        no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        ch   = 6'($urandom_range(0, NUM_CHANNELS - 1));
        down = 1'($urandom_range(0, 1));
        t    = (pick < 6) ? $urandom : now_ms;
      end else begin
        ch = active[$urandom_range(0, 5)];
        if ($urandom_range(0, 99) < 12) intent[ch] = !intent[ch];
        down = ($urandom_range(0, 99) < 15) ? !intent[ch] : intent[ch];
        pick = $urandom_range(0, 99);
        if (pick < 60) now_ms += $urandom_range(0, step_max / 2 + 1);
        else if (pick < 97) now_ms += $urandom_range(step_max / 2, step_max + 3);
        else now_ms += $urandom;
        t = now_ms;
      end
      send_sample(ch, down, t);
    end
    drain();
  endtask

  initial begin : event_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (event_valid && !event_stall)
        board.check_event(source_group, event_key, event_kind, event_time_ms,
                          held_for_ms);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        event_stall <= 1'b1;
        for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clk);
      end else if (stall_left > 0) begin
        event_stall <= 1'b1;
        stall_left--;
      end else begin
        event_stall <= 1'b0;
        if (!no_gaps) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (event_valid && !event_stall) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no transfer for %0d cycles, %0d events still owed", IDLE_LIMIT,
             board.awaited_events.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] start_ms;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) set_config(16'hFFFF, 16'hFFFF, 3'd7, 3'd3);
      else if (p == 1) set_config(16'd0, 16'd1, 3'd7, 3'd0);
      // Short settle and repeat times keep events coming while the receiver holds off.
      else if (p == 2) set_config(16'd3, 16'd2, 3'd7, 3'd2);
      else random_config();
      start_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;
      run_random_phase(PHASE_ITEMS, start_ms, p == 2);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.awaited_events.size() != 0)
      board.report_mismatch($sformatf("%0d events never arrived",
                                      board.awaited_events.size()));
    $display("Ran %0d key samples under %0d register settings plus the reset one.",
             board.samples_taken, settings_used);
    $display("Checked %0d events (press %0d, release %0d, held %0d), %0d mismatches.",
             board.events_checked, board.kind_count[0], board.kind_count[1],
             board.kind_count[2], board.mismatches);
    if (board.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* key_debounce_hold_repeat.f */
sv/kdhr_pkg.sv
sv/kdhr_cfg_regs.sv
sv/kdhr_state_ram.sv
sv/kdhr_update.sv
sv/key_debounce_hold_repeat.sv
tb/testbench.sv
